// ----- hdl/rpn_pkg.sv -----
// shared types and constants for the rpn stack evaluator
package rpn_pkg;

  localparam int DefaultDepth = 128;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4,
    OP_MOD = 4'd5, OP_PEEK = 4'd6, OP_DUP = 4'd7, OP_SWAP = 4'd8, OP_CLEAR = 4'd9,
    OP_FINISH = 4'd10
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_OVERFLOW = 3'd1, ST_UNDERFLOW = 3'd2, ST_DIVZERO = 3'd3,
    ST_INCOMPLETE = 3'd4, ST_SKIPPED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_DIVFIX, S_SWAP2, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic rd_top;    // read entry count-2 into lhs
    logic exec;      // decide outcome of the token
    logic mul_go;    // one partial product step, write back on the last
    logic div_start;
    logic div_step;
    logic div_fix;
    logic swap2;     // second write of swap
    logic emit;      // build result
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic       div_done;
    logic       mul_done;
    logic       is_div_ok;   // div/mod to run on the divider
    logic       is_mul_ok;
    logic       is_swap_ok;
  } stat_t;

endpackage

// ----- hdl/rpn_if.sv -----
// valid/ready channel interfaces
interface rpn_in_if;
  import rpn_pkg::*;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic signed [63:0] operand;
  modport source (output valid, opcode, operand, input ready);
  modport sink (input valid, opcode, operand, output ready);
endinterface

interface rpn_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [63:0] top_value;
  logic               top_valid;
  logic [7:0]         depth;
  modport source (output valid, status, top_value, top_valid, depth, input ready);
  modport sink (input valid, status, top_value, top_valid, depth, output ready);
endinterface

// ----- hdl/rpn_stack_evaluator_top.sv -----
// top level of the rpn stack evaluator
// a token runs through the read, execute and output states; swap adds a second write,
// mul steps the shared 32x32 multiplier, and div and mod run on the divider
// a new token is taken only once the previous one has left the output state, later
// while the previous result still waits in the output register
// reset: synchronous active-high rst empties the stack and clears the error
module rpn_stack_evaluator_top import rpn_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input logic clk,
  input logic rst,
  rpn_in_if.sink    in_ch,
  rpn_out_if.source out_ch
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencing: idle, read second entry, execute, optional multi-cycle, emit
  rpn_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .ctrl
  );

  // stack memory with cached top register plus arithmetic
  rpn_dp #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst, .ctrl, .stat,
    .opcode(in_ch.opcode), .operand(in_ch.operand),
    .status(out_ch.status), .top_value(out_ch.top_value),
    .top_valid(out_ch.top_valid), .depth(out_ch.depth)
  );

endmodule

// ----- hdl/rpn_ctrl.sv -----
// sequencing state machine for the rpn evaluator
module rpn_ctrl import rpn_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state, state_next;
  logic   out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_READ;
      S_READ:   state_next = S_EXEC;
      S_EXEC: begin
        priority if (stat.is_div_ok) state_next = S_DIV;
        else if (stat.is_mul_ok) state_next = S_MUL;
        else if (stat.is_swap_ok) state_next = S_SWAP2;
        else state_next = S_OUT;
      end
      S_MUL:    if (stat.mul_done) state_next = S_OUT;
      S_DIV:    if (stat.div_done) state_next = S_DIVFIX;
      S_DIVFIX: state_next = S_OUT;
      S_SWAP2:  state_next = S_OUT;
      S_OUT:    if (!out_full || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_ready = (state == S_IDLE);
    out_valid = out_full;
    out_full_next = out_full && !out_ready;
    unique case (state)
      S_IDLE:   ctrl.load = in_valid;
      S_READ:   ctrl.rd_top = 1'b1;
      S_EXEC: begin
        ctrl.exec = 1'b1;
        ctrl.div_start = stat.is_div_ok;
      end
      S_MUL:    ctrl.mul_go = 1'b1;
      S_DIV:    ctrl.div_step = 1'b1;
      S_DIVFIX: ctrl.div_fix = 1'b1;
      S_SWAP2:  ctrl.swap2 = 1'b1;
      S_OUT: begin
        if (!out_full || out_ready) begin
          ctrl.emit = 1'b1;
          out_full_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/rpn_dp.sv -----
// stack memory, alu and iterative divider
module rpn_dp import rpn_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_t              ctrl,
  output stat_t              stat,
  input  logic [3:0]         opcode,
  input  logic signed [63:0] operand,
  output logic [2:0]         status,
  output logic signed [63:0] top_value,
  output logic               top_valid,
  output logic [7:0]         depth
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data;
  logic [63:0] top_reg;      // cached top of stack
  logic [CW-1:0] count;
  logic err;

  logic [3:0]  op;
  logic [63:0] opnd, lhs, res;
  logic [2:0]  st;
  logic        wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [63:0] wr_data;

  // divider state
  logic [63:0] quo, rem, dvs;
  logic [6:0]  dcnt;
  logic        neg_q, neg_r;

  // multiplier phase: low x low, low x high, high x low, write back
  logic [1:0]  mph;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  wire [CW-1:0] one = CW'(1);
  wire [CW-1:0] two = CW'(2);
  wire [CW-1:0] full = CW'(DEPTH);
  wire has1 = (count >= one);
  wire has2 = (count >= two);
  wire is_bin = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) ||
                (op == OP_DIV) || (op == OP_MOD);

  assign rd_addr = AW'(count - two);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // divide on magnitudes, one quotient bit per cycle
  wire [63:0] a_mag = lhs[63] ? (64'd0 - lhs) : lhs;
  wire [63:0] b_mag = top_reg[63] ? (64'd0 - top_reg) : top_reg;
  wire [64:0] trial = {rem[63:0], quo[63]} - {1'b0, dvs};

  // one shared 32x32 multiplier, low 64 bits of the product built over 3 steps
  always_comb begin
    unique case (mph)
      2'd0: begin
        mul_a = lhs[31:0];
        mul_b = top_reg[31:0];
      end
      2'd1: begin
        mul_a = lhs[31:0];
        mul_b = top_reg[63:32];
      end
      default: begin
        mul_a = lhs[63:32];
        mul_b = top_reg[31:0];
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign stat.div_done = (dcnt == 7'd0);
  assign stat.mul_done = (mph == 2'd3);
  assign stat.is_div_ok = !err && is_bin && has2 &&
    ((op == OP_DIV) || (op == OP_MOD)) && (top_reg != 64'd0);
  assign stat.is_mul_ok = !err && has2 && (op == OP_MUL);
  assign stat.is_swap_ok = !err && has2 && (op == OP_SWAP);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = AW'(count - one);
    wr_data = top_reg;
    if (ctrl.exec && !err) begin
      unique case (op)
        OP_PUSH: if (count < full) begin
          wr_en = 1'b1; wr_addr = AW'(count); wr_data = opnd;
        end
        OP_DUP: if (has1 && count < full) begin
          wr_en = 1'b1; wr_addr = AW'(count); wr_data = top_reg;
        end
        OP_SWAP: if (has2) begin
          wr_en = 1'b1; wr_addr = AW'(count - one); wr_data = lhs;
        end
        OP_ADD, OP_SUB: if (has2) begin
          wr_en = 1'b1; wr_addr = AW'(count - two);
          wr_data = (op == OP_ADD) ? lhs + top_reg : lhs - top_reg;
        end
        default: ;
      endcase
    end else if ((ctrl.mul_go && stat.mul_done) || ctrl.div_fix) begin
      wr_en = 1'b1;
      wr_addr = AW'(count - one);
      wr_data = res;
    end else if (ctrl.swap2) begin
      wr_en = 1'b1;
      wr_addr = AW'(count - two);
      wr_data = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err <= 1'b0;
      mph <= 2'd0;
    end else begin
      if (ctrl.mul_go) mph <= mph + 2'd1;
      if (ctrl.exec) begin
        priority if (op == OP_FINISH) begin
          count <= '0;
          err <= 1'b0;
        end else if (err) begin
        end else if (op == OP_PUSH) begin
          if (count < full) count <= count + one; else err <= 1'b1;
        end else if (op == OP_DUP) begin
          if (!has1 || count >= full) err <= 1'b1; else count <= count + one;
        end else if (is_bin) begin
          if (!has2) err <= 1'b1;
          else if ((op == OP_DIV || op == OP_MOD) && top_reg == 64'd0) err <= 1'b1;
          else count <= count - one;
        end else if (op == OP_SWAP) begin
          if (!has2) err <= 1'b1;
        end else if (op == OP_CLEAR) begin
          count <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op <= opcode;
      opnd <= operand;
    end
    if (ctrl.rd_top) lhs <= rd_data;
    if (ctrl.exec) begin
      st <= ST_OK;
      res <= top_reg;
      priority if (op == OP_FINISH) begin
        st <= err ? ST_SKIPPED : (count == one ? ST_OK : ST_INCOMPLETE);
      end else if (err) begin
        st <= ST_SKIPPED;
      end else if (op == OP_PUSH) begin
        if (count < full) top_reg <= opnd; else st <= ST_OVERFLOW;
      end else if (op == OP_DUP) begin
        if (!has1) st <= ST_UNDERFLOW; else if (count >= full) st <= ST_OVERFLOW;
      end else if (is_bin) begin
        if (!has2) st <= ST_UNDERFLOW;
        else if ((op == OP_DIV || op == OP_MOD) && top_reg == 64'd0) st <= ST_DIVZERO;
        else if (op == OP_ADD) top_reg <= lhs + top_reg;
        else if (op == OP_SUB) top_reg <= lhs - top_reg;
      end else if (op == OP_SWAP) begin
        if (!has2) st <= ST_UNDERFLOW;
        else begin
          top_reg <= lhs;
          res <= top_reg;
        end
      end
    end
    if (ctrl.mul_go && !stat.mul_done) begin
      if (mph == 2'd0) res <= mul_p;
      else res <= res + {mul_p[31:0], 32'd0};
    end
    if (ctrl.mul_go && stat.mul_done) top_reg <= res;
    if (ctrl.div_start) begin
      quo <= a_mag;
      rem <= '0;
      dvs <= b_mag;
      dcnt <= 7'd64;
      neg_q <= lhs[63] ^ top_reg[63];
      neg_r <= lhs[63];
    end else if (ctrl.div_step && dcnt != 7'd0) begin
      dcnt <= dcnt - 7'd1;
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
    if (ctrl.div_step && dcnt == 7'd0) begin
      if (op == OP_DIV) res <= neg_q ? (64'd0 - quo) : quo;
      else res <= neg_r ? (64'd0 - rem) : rem;
    end
    if (ctrl.div_fix) top_reg <= res;
    if (ctrl.emit) begin
      status <= st;
      if (op == OP_FINISH) begin
        top_valid <= (st == ST_OK);
        top_value <= (st == ST_OK) ? top_reg : 64'd0;
        depth <= 8'd0;
      end else begin
        top_valid <= has1;
        top_value <= has1 ? top_reg : 64'd0;
        depth <= 8'(count);
      end
    end
  end

endmodule
